/* hdl/rfp_pkg.sv */
// Shared types and constants for the reader frame parser.
// No dependencies; imported by rfp_step and rfid_reader_frame_parser.
`default_nettype none

package rfp_pkg;

    // framing bytes
    localparam logic [7:0] START_BYTE = 8'hBB;
    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [7:0] LF_BYTE    = 8'h0A;

    // parser phase, code 7 is unused and treated as hunting
    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_TYPE    = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4,
        PH_CR      = 3'd5,
        PH_LF      = 3'd6
    } t_phase;

    // result kinds
    typedef enum logic [2:0] {
        KIND_PAYLOAD  = 3'd0,
        KIND_ACCEPT   = 3'd1,
        KIND_CSUM_ERR = 3'd2,
        KIND_BAD_CR   = 3'd3,
        KIND_BAD_LF   = 3'd4
    } t_kind;

    // per-frame parser state
    typedef struct packed {
        t_phase     phase;
        logic [7:0] held_type;
        logic [7:0] held_length;
        logic [7:0] bytes_seen;
        logic [7:0] running_sum;
        logic [7:0] received_checksum;
    } t_frame_state;

    // one result request
    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] data_byte;
        logic [7:0] frame_type;
        logic [7:0] frame_length;
    } t_result;

    localparam t_frame_state FRAME_CLEAR = '{
        phase:             PH_HUNT,
        held_type:         8'h00,
        held_length:       8'h00,
        bytes_seen:        8'h00,
        running_sum:       8'h00,
        received_checksum: 8'h00
    };

endpackage

`default_nettype wire

/* hdl/rfp_step.sv */
// One byte of frame parsing: next parser state and optional result.
// Purely combinational; depends on rfp_pkg.
`default_nettype none

module rfp_step (
    input  wire logic [7:0]          i_byte,
    input  wire rfp_pkg::t_frame_state i_state,
    output rfp_pkg::t_frame_state    o_state,
    output rfp_pkg::t_result         o_result
);
    import rfp_pkg::*;

    logic [7:0] w_sum_next;
    logic [7:0] w_seen_next;

    assign w_sum_next  = i_state.running_sum + i_byte;
    assign w_seen_next = i_state.bytes_seen + 8'd1;

    // state update and result per phase
    always_comb begin
        o_state               = i_state;
        o_result.valid        = 1'b0;
        o_result.kind         = KIND_PAYLOAD;
        o_result.data_byte    = 8'h00;
        o_result.frame_type   = i_state.held_type;
        o_result.frame_length = i_state.held_length;
        unique case (i_state.phase)
            PH_TYPE: begin
                o_state.held_type   = i_byte;
                o_state.running_sum = i_byte;
                o_state.phase       = PH_LEN;
            end
            PH_LEN: begin
                o_state.held_length = i_byte;
                o_state.running_sum = w_sum_next;
                o_state.bytes_seen  = 8'h00;
                o_state.phase       = (i_byte == 8'h00) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                o_state.running_sum = w_sum_next;
                o_state.bytes_seen  = w_seen_next;
                o_result.valid      = 1'b1;
                o_result.data_byte  = i_byte;
                if (w_seen_next == i_state.held_length) begin
                    o_state.phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                o_state.received_checksum = i_byte;
                o_state.phase             = PH_CR;
            end
            PH_CR: begin
                // checksum mismatch wins over a wrong terminator
                priority if (i_state.received_checksum != i_state.running_sum) begin
                    o_result.valid = 1'b1;
                    o_result.kind  = KIND_CSUM_ERR;
                    o_state        = FRAME_CLEAR;
                end else if (i_byte != CR_BYTE) begin
                    o_result.valid = 1'b1;
                    o_result.kind  = KIND_BAD_CR;
                    o_state        = FRAME_CLEAR;
                end else begin
                    o_state.phase = PH_LF;
                end
            end
            PH_LF: begin
                o_result.valid = 1'b1;
                o_result.kind  = (i_byte == LF_BYTE) ? KIND_ACCEPT : KIND_BAD_LF;
                o_state        = FRAME_CLEAR;
            end
            default: begin
                // hunting, also the unused phase code
                if (i_byte == START_BYTE) begin
                    o_state       = FRAME_CLEAR;
                    o_state.phase = PH_TYPE;
                end else begin
                    o_state.phase = PH_HUNT;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/rfid_reader_frame_parser.sv */
// Top level of the reader frame parser: input register, parser state, result register.
// Depends on rfp_pkg and rfp_step.
`default_nettype none

// Parses received bytes into frames 0xBB, type, length, payload, checksum, CR, LF.
// Each payload byte comes out as a kind 0 result; the end of a frame gives one
// result (accepted, checksum error, bad CR or bad LF) carrying type and length.
// Header, checksum and hunting bytes give no result. One byte is taken every
// clock while the result side keeps up. A byte is held in the input register
// and is then parsed into the result register, where its result is offered; the
// parse waits while the result register is full and not being emptied. A stalled
// result holds the next byte in the input register, and input stops once both
// registers are full. The rate is set by the parser state update, which handles
// one byte per clock while the result side keeps up.
module rfid_reader_frame_parser (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [2:0]      o_kind,
    output logic [7:0]      o_data_byte,
    output logic [7:0]      o_frame_type,
    output logic [7:0]      o_frame_length
);
    import rfp_pkg::*;

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    t_frame_state r_state;
    t_frame_state n_state;
    t_result      w_result;
    logic         r_out_valid;
    t_result      r_out;
    logic         w_fire;

    // the held byte is parsed when the result slot is free or being emptied
    assign w_fire  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // parser step
    rfp_step u_step (
        .i_byte   (r_in_byte),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FRAME_CLEAR;
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= w_result.valid;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_result.valid) begin
            r_out <= w_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_data_byte    = r_out.data_byte;
    assign o_frame_type   = r_out.frame_type;
    assign o_frame_length = r_out.frame_length;

`ifndef NO_ASSERTIONS
    // any end-of-frame report sends the parser back to hunting
    a_end_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_result.valid && w_result.kind != KIND_PAYLOAD)
        |=> (r_state.phase == PH_HUNT))
        else $error("parser not hunting after end of frame");

    // inside the payload fewer bytes have been seen than declared
    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_PAYLOAD) |-> (r_state.bytes_seen < r_state.held_length))
        else $error("payload count beyond declared length");

    // a held byte that is not parsed stays in the input register
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_fire) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held input byte lost");

    // parser state moves only when a byte is parsed
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(r_state))
        else $error("parser state changed without a byte");
`endif

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for rfid_reader_frame_parser: directed frames, then random frames.
// Depends on rfp_pkg and the parser RTL; the predictor and scoreboard live in this file.
`default_nettype none

module tb;
    import rfp_pkg::*;

    localparam int FRAME_ITEMS  = 1850;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_AT      = 400;
    localparam int CALM_FROM    = 900;
    localparam int CALM_TO      = 1300;

    // damage applied to a random frame
    typedef enum int {
        FAULT_NONE,
        FAULT_CSUM,
        FAULT_CR,
        FAULT_LF,
        FAULT_CUT
    } t_fault;

    // opening frames: stray byte, good empty frame, payload extremes with bad LF,
    // checksum error, bad CR
    localparam logic [7:0] DIRECTED [25] = '{
        8'h00,
        START_BYTE, 8'hFF, 8'h00, 8'hFF, CR_BYTE, LF_BYTE,
        START_BYTE, 8'h00, 8'h02, 8'h00, 8'hFF, 8'h01, CR_BYTE, CR_BYTE,
        START_BYTE, 8'h01, 8'h00, 8'h00, 8'h55,
        START_BYTE, 8'h02, 8'h00, 8'h02, LF_BYTE
    };

    // predicts parser results byte by byte and checks them in order
    class frame_scoreboard;
        t_phase      phase;
        logic [7:0]  cur_type;
        logic [7:0]  cur_len;
        logic [7:0]  payload_count;
        logic [7:0]  sum;
        logic [7:0]  rx_csum;
        t_result     result_q[$];
        int unsigned failures;

        function new();
            clear_frame();
            failures = 0;
        endfunction

        function void clear_frame();
            phase         = PH_HUNT;
            cur_type      = 8'h00;
            cur_len       = 8'h00;
            payload_count = 8'h00;
            sum           = 8'h00;
            rx_csum       = 8'h00;
        endfunction

        function void queue_result(t_kind k, logic [7:0] d);
            t_result r;
            r.valid        = 1'b1;
            r.kind         = k;
            r.data_byte    = d;
            r.frame_type   = cur_type;
            r.frame_length = cur_len;
            result_q.push_back(r);
        endfunction

        // advance the frame state for one accepted request
        function void note_byte(logic [7:0] b);
            case (phase)
                PH_TYPE: begin
                    cur_type = b;
                    sum      = b;
                    phase    = PH_LEN;
                end
                PH_LEN: begin
                    cur_len       = b;
                    sum           = sum + b;
                    payload_count = 8'h00;
                    phase         = (b == 8'h00) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    sum           = sum + b;
                    payload_count = payload_count + 8'h01;
                    queue_result(KIND_PAYLOAD, b);
                    if (payload_count == cur_len)
                        phase = PH_CHECK;
                end
                PH_CHECK: begin
                    rx_csum = b;
                    phase   = PH_CR;
                end
                PH_CR: begin
                    // checksum is judged first, whatever this byte is
                    if (rx_csum != sum) begin
                        queue_result(KIND_CSUM_ERR, 8'h00);
                        clear_frame();
                    end else if (b != CR_BYTE) begin
                        queue_result(KIND_BAD_CR, 8'h00);
                        clear_frame();
                    end else begin
                        phase = PH_LF;
                    end
                end
                PH_LF: begin
                    queue_result((b == LF_BYTE) ? KIND_ACCEPT : KIND_BAD_LF, 8'h00);
                    clear_frame();
                end
                default: begin
                    if (b == START_BYTE) begin
                        clear_frame();
                        phase = PH_TYPE;
                    end else begin
                        phase = PH_HUNT;
                    end
                end
            endcase
        endfunction

        // compare one accepted result with the oldest prediction
        function void check_result(logic [2:0] kind, logic [7:0] data,
                                   logic [7:0] ftype, logic [7:0] flen);
            t_result r;
            if (result_q.size() == 0) begin
                $error("unexpected result: kind %0d data %0h type %0h length %0h",
                       kind, data, ftype, flen);
                failures++;
                return;
            end
            r = result_q.pop_front();
            if (kind !== r.kind) begin
                $error("kind: expected %0d, got %0d", r.kind, kind);
                failures++;
            end
            if (data !== r.data_byte) begin
                $error("data_byte: expected %0h, got %0h", r.data_byte, data);
                failures++;
            end
            if (ftype !== r.frame_type) begin
                $error("frame_type: expected %0h, got %0h", r.frame_type, ftype);
                failures++;
            end
            if (flen !== r.frame_length) begin
                $error("frame_length: expected %0h, got %0h", r.frame_length, flen);
                failures++;
            end
        endfunction

        function int pending();
            return result_q.size();
        endfunction
    endclass

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_ready   = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [2:0] o_kind;
    logic [7:0] o_data_byte;
    logic [7:0] o_frame_type;
    logic [7:0] o_frame_length;

    frame_scoreboard sb;
    logic [7:0]      stim_q[$];
    int unsigned     quiet_cycles = 0;
    int unsigned     hold_ticket  = 0;
    int unsigned     hold_seen    = 0;
    int unsigned     hold_left    = 0;
    logic            calm         = 1'b0;

    rfid_reader_frame_parser u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_frame_type   (o_frame_type),
        .o_frame_length (o_frame_length)
    );

    always #4 i_clk = ~i_clk;

    // result side: random stalls, a long hold-off on request, none while calm
    always @(posedge i_clk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen <= hold_ticket;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (calm) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= 37);
        end
    end

    // handshake monitor and watchdog; results are checked before the new request is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                sb.check_result(o_kind, o_data_byte, o_frame_type, o_frame_length);
            if (i_valid && o_ready)
                sb.note_byte(i_rx_byte);
            if ((o_valid && i_ready) || (i_valid && o_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL rfid_reader_frame_parser");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // append one random frame, possibly damaged; returns its byte count
    function automatic int add_frame(t_fault flt, bit longest);
        logic [7:0] frame_q[$];
        logic [7:0] ftype;
        logic [7:0] flen;
        logic [7:0] csum;
        logic [7:0] b;
        int         keep;
        ftype = 8'($urandom);
        if (longest)
            flen = 8'hFF;
        else if ($urandom_range(0, 39) == 0)
            flen = 8'($urandom_range(7, 254));
        else
            flen = 8'($urandom_range(0, 6));
        csum = ftype + flen;
        frame_q.push_back(START_BYTE);
        frame_q.push_back(ftype);
        frame_q.push_back(flen);
        repeat (flen) begin
            b    = 8'($urandom);
            csum = csum + b;
            frame_q.push_back(b);
        end
        if (flt == FAULT_CSUM)
            csum = csum ^ 8'($urandom_range(1, 255));
        frame_q.push_back(csum);
        b = CR_BYTE;
        if (flt == FAULT_CR) begin
            b = 8'($urandom);
            if (b == CR_BYTE)
                b = b ^ 8'h01;
        end
        frame_q.push_back(b);
        b = LF_BYTE;
        if (flt == FAULT_LF) begin
            b = 8'($urandom);
            if (b == LF_BYTE)
                b = b ^ 8'h01;
        end
        frame_q.push_back(b);
        // a cut frame leaves the parser mid-frame for whatever follows
        if (flt == FAULT_CUT) begin
            keep = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > keep)
                void'(frame_q.pop_back());
        end
        foreach (frame_q[k])
            stim_q.push_back(frame_q[k]);
        return frame_q.size();
    endfunction

    // offer one request, with a random gap unless calm, and wait for acceptance
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (!calm)
            while ($urandom_range(0, 99) < 37)
                gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    initial begin
        int     frame_bytes;
        int     frame_no;
        int     pick;
        t_fault flt;
        sb = new();

        foreach (DIRECTED[k])
            stim_q.push_back(DIRECTED[k]);

        // random part: mostly clean frames, some damaged, occasional line noise
        frame_bytes = 0;
        frame_no    = 0;
        while (frame_bytes < FRAME_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                flt = FAULT_NONE;
            else if (pick < 85)
                flt = FAULT_CSUM;
            else if (pick < 90)
                flt = FAULT_CR;
            else if (pick < 95)
                flt = FAULT_LF;
            else
                flt = FAULT_CUT;
            frame_bytes += add_frame(flt, frame_no == 5);
            frame_no++;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3))
                    stim_q.push_back(8'($urandom));
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < stim_q.size(); i++) begin
            if (i == HOLD_AT)
                hold_ticket <= hold_ticket + 1;
            calm <= (i >= CALM_FROM) && (i < CALM_TO);
            send_byte(stim_q[i]);
        end
        i_valid <= 1'b0;

        // drain outstanding results, then let the pipeline settle
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.failures == 0)
            $display("PASS rfid_reader_frame_parser");
        else
            $display("FAIL rfid_reader_frame_parser");
        $finish;
    end

endmodule

`default_nettype wire
